/* design/tfpc_pkg.sv */
// Shared types and constants of the thermal fever pixel classifier.
// Used by tfpc_front, tfpc_queue, tfpc_back and the top level; no dependencies.
`timescale 1ns / 1ps

package tfpc_pkg;

    // Field widths.
    localparam int RAW_W   = 14;
    localparam int SCALE_W = 16;
    localparam int TEMP_W  = 16;
    localparam int OFS_W   = 10;
    localparam int CNT_W   = 16;
    localparam int PROD_W  = RAW_W + SCALE_W;
    localparam int TQ8_W   = PROD_W - 8;

    // 0.05 degree in Q16, rounded to nearest.
    localparam logic [PROD_W-1:0] HALF_TENTH_Q16 = PROD_W'(3277);

    // Configuration register indexes.
    localparam int CFG_IDX_W = 3;
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SCALE      = 3'd0,
        REG_HUMAN_LOW  = 3'd1,
        REG_WARN       = 3'd2,
        REG_FEVER      = 3'd3,
        REG_HUMAN_HIGH = 3'd4,
        REG_OFFSET     = 3'd5,
        REG_RATIO      = 3'd6
    } cfg_index_t;

    // Per-pixel class codes.
    typedef enum logic [2:0] {
        PC_NONE    = 3'd0,
        PC_NORMAL  = 3'd1,
        PC_WARNING = 3'd2,
        PC_FEVER   = 3'd3,
        PC_ABOVE   = 3'd4
    } pixel_class_t;

    // Frame status codes.
    typedef enum logic [1:0] {
        FS_NO_HUMAN = 2'd0,
        FS_NORMAL   = 2'd1,
        FS_WARNING  = 2'd2,
        FS_FEVER    = 2'd3
    } frame_status_t;

    // Configuration seen by the front part.
    typedef struct packed {
        logic [SCALE_W-1:0] scale_q16;
        logic [TEMP_W-1:0]  human_low_q8;
        logic [TEMP_W-1:0]  warn_q8;
        logic [TEMP_W-1:0]  fever_q8;
        logic [TEMP_W-1:0]  human_high_q8;
        logic [OFS_W-1:0]   simul_offset_q8;
    } front_cfg_t;

    // One classified pixel, as it travels through the queue.
    typedef struct packed {
        pixel_class_t pclass;
        logic         last;
    } class_beat_t;

    // Queue depth.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

endpackage

/* design/tfpc_front.sv */
// Front part: accepts raw pixel beats, converts to Q8 temperature and classifies.
// Depends on tfpc_pkg; pushes class beats into tfpc_queue.
`timescale 1ns / 1ps

module tfpc_front (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  tfpc_pkg::front_cfg_t      cfg,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [tfpc_pkg::RAW_W-1:0] in_raw,
    input  logic                      in_last,
    output logic                      push_valid,
    input  logic                      push_ready,
    output tfpc_pkg::class_beat_t     push_beat
);

    logic                         prod_valid_reg;
    logic [tfpc_pkg::PROD_W-1:0]  prod_reg;
    logic                         last_reg;
    logic [tfpc_pkg::PROD_W-1:0]  rounded;
    logic [tfpc_pkg::TQ8_W-1:0]   temp_q8;
    logic [tfpc_pkg::TQ8_W:0]     t_ofs;
    logic [tfpc_pkg::TQ8_W:0]     low_x;
    logic [tfpc_pkg::TQ8_W:0]     warn_x;
    logic [tfpc_pkg::TQ8_W:0]     fever_x;
    logic [tfpc_pkg::TQ8_W:0]     high_x;
    logic                         is_human;
    tfpc_pkg::pixel_class_t       pclass;

    // The product stage moves on whenever it is empty or its beat enters the queue.
    assign in_ready   = !prod_valid_reg || push_ready;
    assign push_valid = prod_valid_reg;

    // Stage one: raw times scale.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prod_valid_reg <= 1'b0;
        end else if (in_ready) begin
            prod_valid_reg <= in_valid;
        end
        if (in_ready && in_valid) begin
            prod_reg <= tfpc_pkg::PROD_W'(in_raw) * tfpc_pkg::PROD_W'(cfg.scale_q16);
            last_reg <= in_last;
        end
    end

    // Stage two: round to Q8, test the human band, apply the offset and classify.
    always_comb begin
        rounded  = prod_reg + tfpc_pkg::HALF_TENTH_Q16;
        temp_q8  = rounded[tfpc_pkg::PROD_W-1:8];
        t_ofs    = {1'b0, temp_q8} + (tfpc_pkg::TQ8_W + 1)'(cfg.simul_offset_q8);
        low_x    = (tfpc_pkg::TQ8_W + 1)'(cfg.human_low_q8);
        warn_x   = (tfpc_pkg::TQ8_W + 1)'(cfg.warn_q8);
        fever_x  = (tfpc_pkg::TQ8_W + 1)'(cfg.fever_q8);
        high_x   = (tfpc_pkg::TQ8_W + 1)'(cfg.human_high_q8);
        is_human = ({1'b0, temp_q8} >= low_x) && ({1'b0, temp_q8} <= high_x);
        pclass   = tfpc_pkg::PC_NONE;
        if (is_human) begin
            if (t_ofs >= low_x && t_ofs < warn_x) begin
                pclass = tfpc_pkg::PC_NORMAL;
            end else if (t_ofs >= warn_x && t_ofs < fever_x) begin
                pclass = tfpc_pkg::PC_WARNING;
            end else if (t_ofs >= fever_x && t_ofs <= high_x) begin
                pclass = tfpc_pkg::PC_FEVER;
            end else begin
                pclass = tfpc_pkg::PC_ABOVE;
            end
        end
        push_beat.pclass = pclass;
        push_beat.last   = last_reg;
    end

endmodule

/* design/tfpc_queue.sv */
// Short queue of class beats between the front and back parts.
// Depends on tfpc_pkg for the beat type and depth.
`timescale 1ns / 1ps

module tfpc_queue (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  push_valid,
    output logic                  push_ready,
    input  tfpc_pkg::class_beat_t push_beat,
    output logic                  pop_valid,
    input  logic                  pop_ready,
    output tfpc_pkg::class_beat_t pop_beat
);

    localparam int CNT_W = $clog2(tfpc_pkg::QUEUE_DEPTH + 1);

    tfpc_pkg::class_beat_t         mem_reg [tfpc_pkg::QUEUE_DEPTH];
    logic [tfpc_pkg::QPTR_W-1:0]   wr_ptr_reg;
    logic [tfpc_pkg::QPTR_W-1:0]   rd_ptr_reg;
    logic [CNT_W-1:0]              fill_reg;
    logic [CNT_W-1:0]              fill_next;
    logic                          do_push;
    logic                          do_pop;

    assign push_ready = (fill_reg != CNT_W'(tfpc_pkg::QUEUE_DEPTH));
    assign pop_valid  = (fill_reg != '0);
    assign pop_beat   = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // Fill level follows pushes and pops.
    always_comb begin
        fill_next = fill_reg;
        if (do_push && !do_pop) begin
            fill_next = fill_reg + CNT_W'(1);
        end else if (do_pop && !do_push) begin
            fill_next = fill_reg - CNT_W'(1);
        end
    end

    // Pointers and storage.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            fill_reg <= fill_next;
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + tfpc_pkg::QPTR_W'(1);
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + tfpc_pkg::QPTR_W'(1);
            end
        end
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_beat;
        end
    end

endmodule

/* design/tfpc_back.sv */
// Back part: counts human, warning and fever pixels and reports frame status.
// Depends on tfpc_pkg; pops class beats from tfpc_queue and drives the result beat.
`timescale 1ns / 1ps

module tfpc_back #(
    parameter logic [15:0] COUNT_CAP = 16'd32768
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic [15:0]                ratio_thresh_q16,
    input  logic                       pop_valid,
    output logic                       pop_ready,
    input  tfpc_pkg::class_beat_t      pop_beat,
    output logic                       out_valid,
    input  logic                       out_ready,
    output tfpc_pkg::pixel_class_t     out_class,
    output logic                       out_done,
    output tfpc_pkg::frame_status_t    out_status,
    output logic [tfpc_pkg::CNT_W-1:0] out_human,
    output logic [tfpc_pkg::CNT_W-1:0] out_fever,
    output logic [tfpc_pkg::CNT_W-1:0] out_warning
);

    localparam int CW = tfpc_pkg::CNT_W;
    localparam int MW = 2 * CW;

    // Running counters.
    logic [CW-1:0] human_cnt_reg,   human_cnt_next;
    logic [CW-1:0] warning_cnt_reg, warning_cnt_next;
    logic [CW-1:0] fever_cnt_reg,   fever_cnt_next;

    // Count stage: class, last and the frame's closing counts.
    logic                   cnt_valid_reg;
    tfpc_pkg::pixel_class_t cnt_class_reg;
    logic                   cnt_last_reg;
    logic [CW-1:0]          snap_human_reg;
    logic [CW-1:0]          snap_warning_reg;
    logic [CW-1:0]          snap_fever_reg;
    logic                   cnt_adv;
    logic                   do_pop;

    // Status stage.
    logic [MW-1:0]           thresh_prod;
    logic                    fever_exceeds;
    logic                    warn_exceeds;
    tfpc_pkg::frame_status_t status;

    assign cnt_adv   = !out_valid || out_ready;
    assign pop_ready = !cnt_valid_reg || cnt_adv;
    assign do_pop    = pop_valid && pop_ready;

    // Counters saturate at the cap.
    always_comb begin
        human_cnt_next   = human_cnt_reg;
        warning_cnt_next = warning_cnt_reg;
        fever_cnt_next   = fever_cnt_reg;
        if (pop_beat.pclass != tfpc_pkg::PC_NONE && human_cnt_reg < COUNT_CAP) begin
            human_cnt_next = human_cnt_reg + CW'(1);
        end
        if (pop_beat.pclass == tfpc_pkg::PC_WARNING && warning_cnt_reg < COUNT_CAP) begin
            warning_cnt_next = warning_cnt_reg + CW'(1);
        end
        if (pop_beat.pclass == tfpc_pkg::PC_FEVER && fever_cnt_reg < COUNT_CAP) begin
            fever_cnt_next = fever_cnt_reg + CW'(1);
        end
    end

    // Count stage: update the counters, snapshot and clear them at frame end.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_valid_reg   <= 1'b0;
            human_cnt_reg   <= '0;
            warning_cnt_reg <= '0;
            fever_cnt_reg   <= '0;
        end else begin
            if (pop_ready) begin
                cnt_valid_reg <= pop_valid;
            end
            if (do_pop) begin
                if (pop_beat.last) begin
                    human_cnt_reg   <= '0;
                    warning_cnt_reg <= '0;
                    fever_cnt_reg   <= '0;
                end else begin
                    human_cnt_reg   <= human_cnt_next;
                    warning_cnt_reg <= warning_cnt_next;
                    fever_cnt_reg   <= fever_cnt_next;
                end
            end
        end
        if (do_pop) begin
            cnt_class_reg    <= pop_beat.pclass;
            cnt_last_reg     <= pop_beat.last;
            snap_human_reg   <= human_cnt_next;
            snap_warning_reg <= warning_cnt_next;
            snap_fever_reg   <= fever_cnt_next;
        end
    end

    // Ratio tests by cross-multiplication: count * 65536 > thresh * humans.
    always_comb begin
        thresh_prod   = MW'(ratio_thresh_q16) * MW'(snap_human_reg);
        fever_exceeds = {snap_fever_reg, CW'(0)} > thresh_prod;
        warn_exceeds  = {snap_warning_reg, CW'(0)} > thresh_prod;
        if (snap_human_reg == '0) begin
            status = tfpc_pkg::FS_NO_HUMAN;
        end else if (fever_exceeds) begin
            status = tfpc_pkg::FS_FEVER;
        end else if (warn_exceeds) begin
            status = tfpc_pkg::FS_WARNING;
        end else begin
            status = tfpc_pkg::FS_NORMAL;
        end
    end

    // Output register: the result beat waits here until taken.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid <= 1'b0;
        end else if (cnt_adv) begin
            out_valid <= cnt_valid_reg;
        end
        if (cnt_adv && cnt_valid_reg) begin
            out_class <= cnt_class_reg;
            out_done  <= cnt_last_reg;
            if (cnt_last_reg) begin
                out_status  <= status;
                out_human   <= snap_human_reg;
                out_fever   <= snap_fever_reg;
                out_warning <= snap_warning_reg;
            end else begin
                out_status  <= tfpc_pkg::FS_NO_HUMAN;
                out_human   <= '0;
                out_fever   <= '0;
                out_warning <= '0;
            end
        end
    end

endmodule

/* design/thermal_fever_pixel_classifier.sv */
// Top level of the thermal fever pixel classifier: configuration registers and stream ports.
// Depends on tfpc_pkg, tfpc_front, tfpc_queue and tfpc_back.
`timescale 1ns / 1ps

// The block takes one raw 14-bit thermal pixel per beat, with tlast on the last pixel
// of a frame, and returns one result beat per pixel: its class and, on the frame's last
// pixel, the frame status and the human, fever and warning counts. It sustains one pixel
// per clock while m_tready is held high. When the output is free, the accepting edge
// registers a pixel's product; the pixel is then rounded and classified into the queue,
// counted, and run through the ratio multiply and compare into the output register, in
// that order. A four-beat queue between front and back lets either side stall on its
// own. Counters clear at reset and at every frame end and saturate at the smaller of
// MAX_FRAME_PIXELS and 65535. Configuration is written through cfg_wr_en, cfg_index
// and cfg_wdata; the user must write it only while idle, which the block does not enforce.
module thermal_fever_pixel_classifier #(
    parameter int MAX_FRAME_PIXELS = 32768
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Configuration write port.
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_wdata,
    // Pixel input.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,    // [13:0] raw_pixel, [15:14] zero
    input  logic        s_tlast,    // last_in_frame
    // Result output.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,    // [2:0] pixel_class, [4:3] frame_status,
                                    // [20:5] human_total, [36:21] fever_total,
                                    // [52:37] warning_total, [55:53] zero
    output logic        m_tlast     // frame_done
);

    localparam int CAP_INT = (MAX_FRAME_PIXELS < 65535) ? MAX_FRAME_PIXELS : 65535;
    localparam logic [15:0] COUNT_CAP = 16'(CAP_INT);

    tfpc_pkg::front_cfg_t    cfg_reg;
    logic [15:0]             ratio_thresh_reg;
    logic                    push_valid;
    logic                    push_ready;
    tfpc_pkg::class_beat_t   push_beat;
    logic                    pop_valid;
    logic                    pop_ready;
    tfpc_pkg::class_beat_t   pop_beat;
    tfpc_pkg::pixel_class_t  out_class;
    tfpc_pkg::frame_status_t out_status;
    logic [15:0]             out_human;
    logic [15:0]             out_fever;
    logic [15:0]             out_warning;

    // Configuration register file.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.scale_q16       <= 16'd603;
            cfg_reg.human_low_q8    <= 16'd8832;
            cfg_reg.warn_q8         <= 16'd9472;
            cfg_reg.fever_q8        <= 16'd9600;
            cfg_reg.human_high_q8   <= 16'd10752;
            cfg_reg.simul_offset_q8 <= 10'd0;
            ratio_thresh_reg        <= 16'd3277;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                tfpc_pkg::REG_SCALE:      cfg_reg.scale_q16       <= cfg_wdata;
                tfpc_pkg::REG_HUMAN_LOW:  cfg_reg.human_low_q8    <= cfg_wdata;
                tfpc_pkg::REG_WARN:       cfg_reg.warn_q8         <= cfg_wdata;
                tfpc_pkg::REG_FEVER:      cfg_reg.fever_q8        <= cfg_wdata;
                tfpc_pkg::REG_HUMAN_HIGH: cfg_reg.human_high_q8   <= cfg_wdata;
                tfpc_pkg::REG_OFFSET:     cfg_reg.simul_offset_q8 <= cfg_wdata[9:0];
                tfpc_pkg::REG_RATIO:      ratio_thresh_reg        <= cfg_wdata;
                default: ;
            endcase
        end
    end

    tfpc_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg_reg),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_raw     (s_tdata[13:0]),
        .in_last    (s_tlast),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_beat  (push_beat)
    );

    tfpc_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_beat  (push_beat),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_beat   (pop_beat)
    );

    tfpc_back #(
        .COUNT_CAP (COUNT_CAP)
    ) u_back (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .ratio_thresh_q16 (ratio_thresh_reg),
        .pop_valid        (pop_valid),
        .pop_ready        (pop_ready),
        .pop_beat         (pop_beat),
        .out_valid        (m_tvalid),
        .out_ready        (m_tready),
        .out_class        (out_class),
        .out_done         (m_tlast),
        .out_status       (out_status),
        .out_human        (out_human),
        .out_fever        (out_fever),
        .out_warning      (out_warning)
    );

    // Pack the result beat.
    assign m_tdata = {3'b000, out_warning, out_fever, out_human, out_status, out_class};

endmodule
